@@ rtl/mgbp_pkg.sv @@
// Shared types, widths and helpers for the bilinear prolongation unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mgbp_pkg;

  localparam int VALUE_W   = 32;
  localparam int MAX_CW    = 512;
  localparam int COL_W     = $clog2(MAX_CW);
  localparam int ROW_LIMIT = 4096;
  localparam int ROW_W     = $clog2(ROW_LIMIT);
  localparam int CW_W      = 10;
  localparam int CH_W      = 13;
  localparam int PITCH_W   = 10;
  localparam int BASE_W    = 24;
  localparam int X_W       = 10;
  localparam int Y_W       = 13;
  localparam int IDX_W     = 25;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;
  localparam int NUM_PT    = 4;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    REG_COARSE_WIDTH  = 2'd0,
    REG_COARSE_HEIGHT = 2'd1,
    REG_FINE_PITCH    = 2'd2,
    REG_FINE_BASE     = 2'd3
  } reg_idx_t;

  // bit 0: one column left, bit 1: one row up
  typedef enum logic [1:0] {
    PT_OWN        = 2'd0,
    PT_LEFT       = 2'd1,
    PT_ABOVE      = 2'd2,
    PT_UPPER_LEFT = 2'd3
  } pt_kind_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    value_t           left;
    value_t           above;
    value_t           upper_left;
  } ctx_t;

  function automatic value_t sat_value(input logic signed [VALUE_W:0] s);
    value_t r;
    if (s[VALUE_W] != s[VALUE_W-1]) begin
      r = s[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
    end else begin
      r = s[VALUE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/multigrid_bilinear_prolongation_unit.sv @@
// Top level of the bilinear prolongation unit: APB registers, operand and
// result stages, result sequencer. Depends on mgbp_pkg and mgbp_ctx.
//
// Usage: coarse samples are sent in raster order on the in_ request channel,
// each with the old values of the fine points it completes. For each request
// the unit returns 1 to 4 corrected fine points on the out_ channel in the
// order own, left, above, upper-left; out_last_of_item marks the final one.
// A request passes the operand stage, result sequencer and output register in order.
// Throughput: one request per cycle when it yields one result and out_ready is high;
// a request with more results (4 inside the grid) holds the sequencer until its last result
// is loaded, one result per cycle on the single output register while out_ready is high.
// The previous-row store is a 512 x 32 memory with one read and one write
// port, read one request ahead of use.
// Reset: rst_n (synchronous) clears the raster position, the left and upper-left
// neighbor samples, pipeline valids and loads the register defaults. Row store contents are
// not cleared. When out_ready is low the output holds; the sequencer and the
// operand stage still absorb up to one request each before in_ready drops.
// The user must write registers only while the unit is idle; the unit does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module multigrid_bilinear_prolongation_unit import mgbp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire value_t            in_coarse_value,
  input  wire value_t            in_fine_own,
  input  wire value_t            in_fine_left,
  input  wire value_t            in_fine_above,
  input  wire value_t            in_fine_upper_left,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [X_W-1:0]         out_fine_x,
  output logic [Y_W-1:0]         out_fine_y,
  output logic [IDX_W-1:0]       out_fine_index,
  output value_t                 out_corrected_value,
  output logic                   out_last_of_item,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic [APB_DW-1:0]      cfg_prdata,
  output logic                   cfg_pready
);

  logic [CW_W-1:0]    coarse_width_r;
  logic [CH_W-1:0]    coarse_height_r;
  logic [PITCH_W-1:0] fine_pitch_r;
  logic [BASE_W-1:0]  fine_base_r;
  reg_idx_t           reg_sel;

  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[APB_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coarse_width_r  <= CW_W'(512);
      coarse_height_r <= CH_W'(512);
      fine_pitch_r    <= PITCH_W'(1023);
      fine_base_r     <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_sel)
        REG_COARSE_WIDTH:  coarse_width_r  <= cfg_pwdata[CW_W-1:0];
        REG_COARSE_HEIGHT: coarse_height_r <= cfg_pwdata[CH_W-1:0];
        REG_FINE_PITCH:    fine_pitch_r    <= cfg_pwdata[PITCH_W-1:0];
        REG_FINE_BASE:     fine_base_r     <= cfg_pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_COARSE_WIDTH:  cfg_prdata = APB_DW'(coarse_width_r);
      REG_COARSE_HEIGHT: cfg_prdata = APB_DW'(coarse_height_r);
      REG_FINE_PITCH:    cfg_prdata = APB_DW'(fine_pitch_r);
      REG_FINE_BASE:     cfg_prdata = APB_DW'(fine_base_r);
      default:           cfg_prdata = '0;
    endcase
  end

  // operand stage
  logic   in_take;
  logic   s1_valid_r;
  ctx_t   ctx;
  ctx_t   s1_ctx_r;
  value_t s1_c_r;
  value_t s1_own_r;
  value_t s1_left_r;
  value_t s1_above_r;
  value_t s1_ul_r;
  logic   s2_take;

  assign in_ready = !s1_valid_r || s2_take;
  assign in_take  = in_valid && in_ready;

  mgbp_ctx u_ctx (
    .clk           (clk),
    .rst_n         (rst_n),
    .take          (in_take),
    .coarse_value  (in_coarse_value),
    .coarse_width  (coarse_width_r),
    .coarse_height (coarse_height_r),
    .ctx           (ctx)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s2_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_ctx_r   <= ctx;
      s1_c_r     <= in_coarse_value;
      s1_own_r   <= in_fine_own;
      s1_left_r  <= in_fine_left;
      s1_above_r <= in_fine_above;
      s1_ul_r    <= in_fine_upper_left;
    end
  end

  // correction arithmetic
  logic signed [VALUE_W:0]   sum_left;
  logic signed [VALUE_W:0]   sum_above;
  logic signed [VALUE_W+1:0] sum_quad;
  value_t                    half_left;
  value_t                    half_above;
  value_t                    quarter;
  value_t                    val_nxt [NUM_PT];
  logic [NUM_PT-1:0]         mask_nxt;
  logic [Y_W-1:0]            y0;
  logic [Y_W-1:0]            y1;
  logic [IDX_W-1:0]          rb0_nxt;
  logic [IDX_W-1:0]          rb1_nxt;

  always_comb begin
    sum_left   = (VALUE_W+1)'(s1_c_r) + (VALUE_W+1)'(s1_ctx_r.left);
    sum_above  = (VALUE_W+1)'(s1_c_r) + (VALUE_W+1)'(s1_ctx_r.above);
    sum_quad   = (VALUE_W+2)'(sum_left)
               + (VALUE_W+2)'(s1_ctx_r.above) + (VALUE_W+2)'(s1_ctx_r.upper_left);
    half_left  = sum_left[VALUE_W:1];
    half_above = sum_above[VALUE_W:1];
    quarter    = sum_quad[VALUE_W+1:2];
    val_nxt[PT_OWN]        = sat_value((VALUE_W+1)'(s1_own_r) + (VALUE_W+1)'(s1_c_r));
    val_nxt[PT_LEFT]       = sat_value((VALUE_W+1)'(s1_left_r) + (VALUE_W+1)'(half_left));
    val_nxt[PT_ABOVE]      = sat_value((VALUE_W+1)'(s1_above_r) + (VALUE_W+1)'(half_above));
    val_nxt[PT_UPPER_LEFT] = sat_value((VALUE_W+1)'(s1_ul_r) + (VALUE_W+1)'(quarter));
    mask_nxt[PT_OWN]        = 1'b1;
    mask_nxt[PT_LEFT]       = s1_ctx_r.col != '0;
    mask_nxt[PT_ABOVE]      = s1_ctx_r.row != '0;
    mask_nxt[PT_UPPER_LEFT] = mask_nxt[PT_LEFT] && mask_nxt[PT_ABOVE];
    y0      = {s1_ctx_r.row, 1'b0};
    y1      = y0 - Y_W'(1);
    rb0_nxt = IDX_W'(fine_base_r) + IDX_W'(fine_pitch_r) * IDX_W'(y0);
    rb1_nxt = IDX_W'(fine_base_r) + IDX_W'(fine_pitch_r) * IDX_W'(y1);
  end

  // result sequencer
  logic [NUM_PT-1:0] s2_mask_r;
  value_t            s2_val_r [NUM_PT];
  logic [COL_W-1:0]  s2_col_r;
  logic [ROW_W-1:0]  s2_row_r;
  logic [IDX_W-1:0]  s2_rb0_r;
  logic [IDX_W-1:0]  s2_rb1_r;
  pt_kind_t          kind;
  logic [NUM_PT-1:0] rem;
  logic              s2_busy;
  logic              out_load;
  logic              s2_done;
  logic [X_W-1:0]    sel_x;
  logic [Y_W-1:0]    sel_y;

  always_comb begin
    if (s2_mask_r[PT_OWN]) begin
      kind = PT_OWN;
    end else if (s2_mask_r[PT_LEFT]) begin
      kind = PT_LEFT;
    end else if (s2_mask_r[PT_ABOVE]) begin
      kind = PT_ABOVE;
    end else begin
      kind = PT_UPPER_LEFT;
    end
    rem      = s2_mask_r & ~(NUM_PT'(1) << kind);
    s2_busy  = |s2_mask_r;
    out_load = s2_busy && (!out_valid || out_ready);
    s2_done  = out_load && (rem == '0);
    s2_take  = s1_valid_r && (!s2_busy || s2_done);
    sel_x    = {s2_col_r, 1'b0} - X_W'(kind[0]);
    sel_y    = {s2_row_r, 1'b0} - Y_W'(kind[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_mask_r <= '0;
    end else if (s2_take) begin
      s2_mask_r <= mask_nxt;
    end else if (out_load) begin
      s2_mask_r <= rem;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_val_r <= val_nxt;
      s2_col_r <= s1_ctx_r.col;
      s2_row_r <= s1_ctx_r.row;
      s2_rb0_r <= rb0_nxt;
      s2_rb1_r <= rb1_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_fine_x          <= sel_x;
      out_fine_y          <= sel_y;
      out_fine_index      <= (kind[1] ? s2_rb1_r : s2_rb0_r) + IDX_W'(sel_x);
      out_corrected_value <= s2_val_r[kind];
      out_last_of_item    <= rem == '0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/mgbp_ctx.sv @@
// Raster position counters, neighbor samples and previous-row store.
// Depends on mgbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mgbp_ctx import mgbp_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             take,
  input  wire value_t           coarse_value,
  input  wire logic [CW_W-1:0]  coarse_width,
  input  wire logic [CH_W-1:0]  coarse_height,
  output ctx_t                  ctx
);

  value_t           row_mem [MAX_CW];
  value_t           above_r;
  value_t           left_r;
  value_t           upper_left_r;
  logic [COL_W-1:0] col_r;
  logic [COL_W-1:0] col_nxt;
  logic [ROW_W-1:0] row_r;
  logic [ROW_W-1:0] row_nxt;
  logic [CW_W-1:0]  wc;
  logic [CH_W-1:0]  hc;
  logic             end_col;
  logic             end_row;

  always_comb begin
    if (coarse_width == '0) begin
      wc = CW_W'(1);
    end else if (coarse_width > CW_W'(MAX_CW)) begin
      wc = CW_W'(MAX_CW);
    end else begin
      wc = coarse_width;
    end
    if (coarse_height == '0) begin
      hc = CH_W'(1);
    end else if (coarse_height > CH_W'(ROW_LIMIT)) begin
      hc = CH_W'(ROW_LIMIT);
    end else begin
      hc = coarse_height;
    end
    end_col = ((CW_W+1)'(col_r) + (CW_W+1)'(1)) >= (CW_W+1)'(wc);
    end_row = ((CH_W+1)'(row_r) + (CH_W+1)'(1)) >= (CH_W+1)'(hc);
    col_nxt = col_r;
    row_nxt = row_r;
    if (take) begin
      if (end_col) begin
        col_nxt = '0;
        row_nxt = end_row ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      left_r       <= '0;
      upper_left_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      if (take) begin
        left_r       <= coarse_value;
        upper_left_r <= above_r;
      end
    end
  end

  // above_r always holds the entry at col_r; bypass the write of this edge
  always_ff @(posedge clk) begin
    if (take) begin
      row_mem[col_r] <= coarse_value;
    end
    if (take && (col_r == col_nxt)) begin
      above_r <= coarse_value;
    end else begin
      above_r <= row_mem[col_nxt];
    end
  end

  assign ctx = '{col: col_r, row: row_r, left: left_r, above: above_r,
                 upper_left: upper_left_r};

endmodule

`default_nettype wire

@@ tb/multigrid_bilinear_prolongation_unit_tb.sv @@
// Self-checking testbench for multigrid_bilinear_prolongation_unit: directed rows, then random
// coarse samples under several register settings, with results compared to a built-in predictor.
// Depends on mgbp_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module multigrid_bilinear_prolongation_unit_tb;
  import mgbp_pkg::*;

  localparam int RAND_ITEMS  = 92;
  localparam int LONG_HOLD   = 200;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DIR_ROWS    = 18;

  typedef struct {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [IDX_W-1:0] idx;
    value_t           val;
    logic             last;
  } fine_pt_t;

  typedef struct {
    int     cfg_set;
    value_t coarse;
    value_t own;
    value_t left;
    value_t above;
    value_t upper_left;
    bit     typed;
    value_t want;
  } dir_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  value_t            in_coarse_value;
  value_t            in_fine_own;
  value_t            in_fine_left;
  value_t            in_fine_above;
  value_t            in_fine_upper_left;
  logic              out_valid;
  logic              out_ready;
  logic [X_W-1:0]    out_fine_x;
  logic [Y_W-1:0]    out_fine_y;
  logic [IDX_W-1:0]  out_fine_index;
  value_t            out_corrected_value;
  logic              out_last_of_item;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [APB_AW-1:0] cfg_paddr;
  logic [APB_DW-1:0] cfg_pwdata;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // predictor state
  fine_pt_t         pending[$];
  value_t           row_above [MAX_CW];
  bit               row_written [MAX_CW];
  value_t           left_s;
  value_t           upleft_s;
  int               ccol;
  int               crow;
  logic [CW_W-1:0]  reg_cw;
  logic [CH_W-1:0]  reg_ch;
  logic [PITCH_W-1:0] reg_pitch;
  logic [BASE_W-1:0]  reg_base;

  int mismatches = 0;
  int cycles = 0;
  bit hold_req = 0;
  bit hold_active = 0;

  multigrid_bilinear_prolongation_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_coarse_value     (in_coarse_value),
    .in_fine_own         (in_fine_own),
    .in_fine_left        (in_fine_left),
    .in_fine_above       (in_fine_above),
    .in_fine_upper_left  (in_fine_upper_left),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_fine_x          (out_fine_x),
    .out_fine_y          (out_fine_y),
    .out_fine_index      (out_fine_index),
    .out_corrected_value (out_corrected_value),
    .out_last_of_item    (out_last_of_item),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_width(logic [CW_W-1:0] raw);
    return (raw == 0) ? 1 : (raw > MAX_CW) ? MAX_CW : int'(raw);
  endfunction

  function automatic value_t add_sat(value_t old, longint corr);
    longint s;
    s = longint'(old) + corr;
    if (s > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
    if (s < -64'sh8000_0000) return 32'h8000_0000;
    return value_t'(s);
  endfunction

  function automatic void push_pt(int x, int y, value_t v);
    fine_pt_t p;
    longint   flat;
    flat   = longint'(reg_base) + x + longint'(reg_pitch) * y;
    p.x    = x[X_W-1:0];
    p.y    = y[Y_W-1:0];
    p.idx  = flat[IDX_W-1:0];
    p.val  = v;
    p.last = 1'b0;
    pending.push_back(p);
  endfunction

  // fine points completed by one coarse sample, in order own, left, above, upper-left
  function automatic void prolong_sample(value_t c, value_t own, value_t left, value_t above,
                                         value_t ul, bit typed, value_t want);
    int     w, h, i, j, first;
    longint cc, above_c;
    w     = eff_width(reg_cw);
    h     = (reg_ch == 0) ? 1 : (reg_ch > ROW_LIMIT) ? ROW_LIMIT : int'(reg_ch);
    i     = ccol;
    j     = crow;
    cc    = c;
    above_c = row_above[i];
    first = pending.size();
    push_pt(2 * i, 2 * j, add_sat(own, cc));
    if (i > 0) push_pt(2 * i - 1, 2 * j, add_sat(left, (cc + left_s) >>> 1));
    if (j > 0) push_pt(2 * i, 2 * j - 1, add_sat(above, (cc + above_c) >>> 1));
    if (i > 0 && j > 0) begin
      push_pt(2 * i - 1, 2 * j - 1, add_sat(ul, (cc + left_s + above_c + upleft_s) >>> 2));
    end
    pending[pending.size() - 1].last = 1'b1;
    if (typed) pending[first].val = want;
    upleft_s       = value_t'(above_c);
    left_s         = c;
    row_above[i]   = c;
    row_written[i] = 1'b1;
    if (i + 1 >= w) begin
      ccol = 0;
      crow = (j + 1 >= h) ? 0 : j + 1;
    end else begin
      ccol = i + 1;
    end
  endfunction

  // a new width must not make the rest of the grid read a row entry never written
  function automatic bit width_is_safe(logic [CW_W-1:0] raw);
    int w2, top, k;
    if (crow == 0) return 1'b1;
    w2  = eff_width(raw);
    top = (w2 - 1 > ccol) ? w2 - 1 : ccol;
    for (k = ccol; k <= top; k++) begin
      if (!row_written[k]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic value_t rand_value();
    value_t v;
    case ($urandom_range(0, 7))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = value_t'($urandom_range(0, 3)) - 2;
      3: v = {2'b01, 30'($urandom)};
      4: v = {2'b10, 30'($urandom)};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 11) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycles, got, want);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [31:0] d);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = {r, 2'b00};
    cfg_pwdata  = d;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    case (r)
      REG_COARSE_WIDTH:  reg_cw    = d[CW_W-1:0];
      REG_COARSE_HEIGHT: reg_ch    = d[CH_W-1:0];
      REG_FINE_PITCH:    reg_pitch = d[PITCH_W-1:0];
      REG_FINE_BASE:     reg_base  = d[BASE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_request(input value_t c, own, left, above, ul, input bit typed,
                              input value_t want, input int gap);
    @(negedge clk);
    in_valid           = 1'b1;
    in_coarse_value    = c;
    in_fine_own        = own;
    in_fine_left       = left;
    in_fine_above      = above;
    in_fine_upper_left = ul;
    do @(posedge clk); while (!in_ready);
    prolong_sample(c, own, left, above, ul, typed, want);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    dir_row_t    dir_rows [DIR_ROWS];
    logic [31:0] v;
    int          tries;
    int          n;
    int          phase;
    int          rand_sent;
    bit          burst;

    in_valid           = 1'b0;
    in_coarse_value    = '0;
    in_fine_own        = '0;
    in_fine_left       = '0;
    in_fine_above      = '0;
    in_fine_upper_left = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    rst_n              = 1'b0;
    reg_cw    = 10'd512;
    reg_ch    = 13'd512;
    reg_pitch = 10'd1023;
    reg_base  = '0;
    ccol      = 0;
    crow      = 0;
    left_s    = '0;
    upleft_s  = '0;
    foreach (row_above[k]) begin
      row_above[k]   = '0;
      row_written[k] = 1'b0;
    end

    // cfg_set 1: width and height 0 (clamped to 1), every sample at the origin
    // cfg_set 2: 3 x 2 grid, all four point kinds, then wrap to row 0
    dir_rows = '{
      '{0, 32'h0001_8000, 32'h0002_4000, 32'h1111_1111, 32'h2222_2222, 32'h3333_3333,
        1, 32'h0003_C000},
      '{0, 32'hFFFF_FFFF, 32'h0000_0010, 32'h7FFF_FFFF, 32'h1234_5678, 32'h0, 0, 0},
      '{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 0, 0},
      '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001, 32'h0, 32'h0, 0, 0},
      '{1, 32'h0000_0003, 32'h0000_0005, 32'hFFFF_FFFE, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 0, 0},
      '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'hFFFF_0000,
        1, 32'h7FFF_FFFF},
      '{0, 32'h8000_0000, 32'h8000_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h0000_FFFF,
        1, 32'h8000_0000},
      '{0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h2, 32'h3, 1, 32'hFFFF_FFFF},
      '{0, 32'h4000_0000, 32'h4000_0000, 32'h4, 32'h5, 32'h6, 1, 32'h7FFF_FFFF},
      '{0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7, 32'h8, 32'h9, 1, 32'hFFFF_FFFE},
      '{2, 32'hFFFF_FFFD, 32'h0001_0000, 32'hDEAD_0001, 32'hDEAD_0002, 32'hDEAD_0003, 0, 0},
      '{0, 32'h0000_0004, 32'hFFFF_0000, 32'h0000_0007, 32'hDEAD_0004, 32'hDEAD_0005, 0, 0},
      '{0, 32'hFFFF_FFF9, 32'h7FFF_FFF0, 32'h8000_0001, 32'hDEAD_0006, 32'hDEAD_0007, 0, 0},
      '{0, 32'h0000_0005, 32'h0000_0000, 32'hDEAD_0008, 32'hFFFF_FFFF, 32'hDEAD_0009, 0, 0},
      '{0, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'hFFFF_FFFB, 0, 0},
      '{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0},
      '{0, 32'h8000_0000, 32'h8000_0000, 32'hDEAD_000A, 32'hDEAD_000B, 32'hDEAD_000C, 0, 0},
      '{0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hDEAD_000D, 32'hDEAD_000E, 0, 0}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_rows[r].cfg_set == 1) begin
        wait_drain();
        write_reg(REG_COARSE_WIDTH, 32'd0);
        write_reg(REG_COARSE_HEIGHT, 32'd0);
        write_reg(REG_FINE_PITCH, 32'd1023);
        write_reg(REG_FINE_BASE, 32'hFF_FFFF);
      end else if (dir_rows[r].cfg_set == 2) begin
        wait_drain();
        write_reg(REG_COARSE_WIDTH, 32'd3);
        write_reg(REG_COARSE_HEIGHT, 32'd2);
        write_reg(REG_FINE_PITCH, 32'd7);
        write_reg(REG_FINE_BASE, 32'hAB_CDEF);
      end
      send_request(dir_rows[r].coarse, dir_rows[r].own, dir_rows[r].left, dir_rows[r].above,
                   dir_rows[r].upper_left, dir_rows[r].typed, dir_rows[r].want, pick_gap());
    end

    phase     = 0;
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      wait_drain();
      if ($urandom_range(0, 2) != 0) begin
        tries = 0;
        do begin
          case ($urandom_range(0, 7))
            0: v = 32'd0;
            1: v = 32'd1023;
            2: v = 32'd512;
            3: v = 32'd1;
            default: v = $urandom_range(2, 6);
          endcase
          tries++;
        end while (!width_is_safe(v[CW_W-1:0]) && tries < 8);
        if (!width_is_safe(v[CW_W-1:0])) v = 32'(reg_cw);
        write_reg(REG_COARSE_WIDTH, v);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 7))
          0: v = 32'd0;
          1: v = 32'd8191;
          2: v = 32'd4096;
          default: v = $urandom_range(1, 4);
        endcase
        write_reg(REG_COARSE_HEIGHT, v);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 3))
          0: v = 32'd0;
          1: v = 32'd1023;
          default: v = $urandom_range(0, 1023);
        endcase
        write_reg(REG_FINE_PITCH, v);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 3))
          0: v = 32'd0;
          1: v = 32'hFF_FFFF;
          default: v = $urandom;
        endcase
        write_reg(REG_FINE_BASE, v);
      end

      burst = ($urandom_range(0, 3) == 0);
      n     = $urandom_range(8, 20);
      if (phase == 1) begin
        // sink stalls while requests keep coming, so the unit backs up
        hold_req = 1'b1;
        wait (hold_active);
        burst = 1'b1;
        n     = 30;
      end
      if (n > RAND_ITEMS - rand_sent) n = RAND_ITEMS - rand_sent;
      repeat (n) begin
        send_request(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                     1'b0, '0, burst ? 0 : pick_gap());
        rand_sent++;
      end
      phase++;
    end

    wait_drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : result_sink
    int len;
    int mode;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_active = 1'b1;
        @(negedge clk);
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req    = 1'b0;
        hold_active = 1'b0;
      end else begin
        mode = $urandom_range(0, 9);
        len  = (mode == 9) ? $urandom_range(10, 50) : $urandom_range(1, 16);
        repeat (len) begin
          @(negedge clk);
          out_ready = (mode < 4) ? 1'b1 : (mode < 9) ? ($urandom_range(0, 3) != 0) : 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    fine_pt_t e;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
      if (pending.size() == 0) begin
        flag_mismatch("result with none pending, fine_index", 32'(out_fine_index), '0);
      end else begin
        e = pending.pop_front();
        if (out_fine_x !== e.x) flag_mismatch("fine_x", 32'(out_fine_x), 32'(e.x));
        if (out_fine_y !== e.y) flag_mismatch("fine_y", 32'(out_fine_y), 32'(e.y));
        if (out_fine_index !== e.idx) begin
          flag_mismatch("fine_index", 32'(out_fine_index), 32'(e.idx));
        end
        if (out_corrected_value !== e.val) begin
          flag_mismatch("corrected_value", out_corrected_value, e.val);
        end
        if (out_last_of_item !== e.last) begin
          flag_mismatch("last_of_item", 32'(out_last_of_item), 32'(e.last));
        end
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("timeout after %0d cycles", cycles);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
